### rtl/core/taqe_pkg.sv
// ----------------------------------------------------------------------------
// taqe_pkg
// Shared types and constants for the tree ancestor query engine.
// ----------------------------------------------------------------------------
package taqe_pkg;

  localparam int FUNC_W  = 2;
  localparam int NODE_W  = 10;
  localparam int TIME_W  = 12;
  localparam int DEPTH_W = 10;
  localparam int LEN_W   = 11;

  // item function codes
  localparam logic [FUNC_W-1:0] FN_ENTER = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LEAVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0]  entry_time;
    logic [TIME_W-1:0]  exit_time;
    logic [DEPTH_W-1:0] depth;
  } node_rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ISSUE,
    ST_EN_RDV,
    ST_EN_WR,
    ST_EN_LVL_RD,
    ST_EN_LVL_WR,
    ST_LV_WR,
    ST_Q_RDB,
    ST_Q_TEST,
    ST_Q_UP,
    ST_Q_CHK,
    ST_Q_PAR,
    ST_Q_LEN
  } state_e;

  // edges between two nodes, wraps modulo 2^LEN_W
  function automatic logic [LEN_W-1:0] path_len(logic [DEPTH_W-1:0] da,
                                                logic [DEPTH_W-1:0] db,
                                                logic [DEPTH_W-1:0] dc);
    return LEN_W'({1'b0, da}) + LEN_W'({1'b0, db}) - LEN_W'({dc, 1'b0});
  endfunction

endpackage

### rtl/core/taqe_ram.sv
// ----------------------------------------------------------------------------
// taqe_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module taqe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tree_ancestor_query_engine_top.sv
// ----------------------------------------------------------------------------
// tree_ancestor_query_engine_top
// Enter fills the jump table one level at a time through the ancestor RAM.
// Query ends at the done strobe, early when one node contains the other;
// each lifting level costs an ancestor read then a node read. Node numbers
// first pass through index reduction steps (none when MAX_NODES >= 1024).
// One item at a time, and the done strobe cannot be held off. Reset clears
// control and the time stamp; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module tree_ancestor_query_engine_top #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [taqe_pkg::FUNC_W-1:0]  func_i,
  input  logic [taqe_pkg::NODE_W-1:0]  node_i,
  input  logic [taqe_pkg::NODE_W-1:0]  parent_node_i,
  input  logic [taqe_pkg::NODE_W-1:0]  other_node_i,
  output logic                         done_o,
  output logic [taqe_pkg::NODE_W-1:0]  common_ancestor_o,
  output logic [taqe_pkg::LEN_W-1:0]   path_length_o
);

  import taqe_pkg::*;

  // steps of conditional subtraction of MAX_NODES << k that fit a node number
  function automatic int red_steps(int m);
    int n;
    n = 0;
    for (int k = 0; k < NODE_W; k++) begin
      if ((m << k) < (1 << NODE_W)) n++;
    end
    return n;
  endfunction

  localparam int NW        = $clog2(MAX_NODES);
  localparam int LW        = $clog2(LIFT_LEVELS);
  localparam int AncDepth  = MAX_NODES * (2 ** LW);
  localparam int RedSteps  = red_steps(MAX_NODES);
  localparam int RcW       = 4;
  localparam logic [NODE_W-1:0] RedBase =
    (MAX_NODES < (1 << NODE_W)) ? NODE_W'(MAX_NODES) : '0;
  localparam logic [LW-1:0] LvlTop = LW'(LIFT_LEVELS - 1);

  function automatic logic [NODE_W-1:0] red_step(logic [NODE_W-1:0] x,
                                                 logic [NODE_W-1:0] s);
    return (x >= s) ? x - s : x;
  endfunction

  state_e            state_q, state_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic              root_q, root_d;
  logic [NODE_W-1:0] v_lane_q, v_lane_d;
  logic [NODE_W-1:0] p_lane_q, p_lane_d;
  logic [NODE_W-1:0] b_lane_q, b_lane_d;
  logic [RcW-1:0]    red_cnt_q, red_cnt_d;
  logic [NW-1:0]     cur_q, cur_d;
  logic [NW-1:0]     up_q, up_d;
  logic [LW-1:0]     lvl_q, lvl_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  node_rec_t         a_rec_q, a_rec_d;
  node_rec_t         b_rec_q, b_rec_d;
  logic [TIME_W-1:0] ts_q, ts_d;
  logic              done_q, done_d;
  logic [NODE_W-1:0] ca_q, ca_d;
  logic [LEN_W-1:0]  len_q, len_d;

  logic [NODE_W-1:0] red_sub;
  logic [NW-1:0]     v_idx, p_idx, b_idx;
  logic              ab_anc, ba_anc, up_anc;
  logic [NW-1:0]     a_next;

  // RAM ports
  logic              node_we;
  logic [NW-1:0]     node_waddr, node_raddr;
  node_rec_t         node_wdata, node_rd;
  logic              anc_we;
  logic [NW+LW-1:0]  anc_waddr, anc_raddr;
  logic [NW-1:0]     anc_wdata, anc_rd;

  taqe_ram #(
    .WIDTH ($bits(node_rec_t)),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rd)
  );

  taqe_ram #(
    .WIDTH (NW),
    .DEPTH (AncDepth)
  ) u_anc_ram (
    .clk_i   (clk_i),
    .we_i    (anc_we),
    .waddr_i (anc_waddr),
    .wdata_i (anc_wdata),
    .raddr_i (anc_raddr),
    .rdata_o (anc_rd)
  );

  assign red_sub = RedBase << (red_cnt_q - RcW'(1));
  assign v_idx   = NW'(v_lane_q);
  assign p_idx   = NW'(p_lane_q);
  assign b_idx   = NW'(b_lane_q);

  assign ab_anc = (a_rec_q.entry_time <= node_rd.entry_time) &&
                  (a_rec_q.exit_time  >= node_rd.exit_time);
  assign ba_anc = (node_rd.entry_time <= a_rec_q.entry_time) &&
                  (node_rd.exit_time  >= a_rec_q.exit_time);
  assign up_anc = (node_rd.entry_time <= b_rec_q.entry_time) &&
                  (node_rd.exit_time  >= b_rec_q.exit_time);
  assign a_next = up_anc ? cur_q : up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ts_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ts_q    <= ts_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    root_q    <= root_d;
    v_lane_q  <= v_lane_d;
    p_lane_q  <= p_lane_d;
    b_lane_q  <= b_lane_d;
    red_cnt_q <= red_cnt_d;
    cur_q     <= cur_d;
    up_q      <= up_d;
    lvl_q     <= lvl_d;
    depth_q   <= depth_d;
    a_rec_q   <= a_rec_d;
    b_rec_q   <= b_rec_d;
    ca_q      <= ca_d;
    len_q     <= len_d;
  end

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    root_d    = root_q;
    v_lane_d  = v_lane_q;
    p_lane_d  = p_lane_q;
    b_lane_d  = b_lane_q;
    red_cnt_d = red_cnt_q;
    cur_d     = cur_q;
    up_d      = up_q;
    lvl_d     = lvl_q;
    depth_d   = depth_q;
    a_rec_d   = a_rec_q;
    b_rec_d   = b_rec_q;
    ts_d      = ts_q;
    done_d    = 1'b0;
    ca_d      = ca_q;
    len_d     = len_q;

    node_we    = 1'b0;
    node_waddr = v_idx;
    node_wdata = node_rd;
    node_raddr = v_idx;
    anc_we     = 1'b0;
    anc_waddr  = {v_idx, lvl_q};
    anc_wdata  = anc_rd;
    anc_raddr  = {cur_q, lvl_q};

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          func_d    = func_i;
          root_d    = (node_i == parent_node_i);
          v_lane_d  = node_i;
          p_lane_d  = parent_node_i;
          b_lane_d  = other_node_i;
          red_cnt_d = RcW'(RedSteps);
          if (func_i == FN_ENTER || func_i == FN_LEAVE || func_i == FN_QUERY) begin
            state_d = (RedSteps > 0) ? ST_REDUCE : ST_ISSUE;
          end
        end
      end

      // node numbers reduced modulo MAX_NODES, one subtract step a cycle
      ST_REDUCE: begin
        v_lane_d  = red_step(v_lane_q, red_sub);
        p_lane_d  = red_step(p_lane_q, red_sub);
        b_lane_d  = red_step(b_lane_q, red_sub);
        red_cnt_d = red_cnt_q - RcW'(1);
        if (red_cnt_q == RcW'(1)) state_d = ST_ISSUE;
      end

      ST_ISSUE: begin
        unique case (func_q)
          FN_ENTER: begin
            node_raddr = p_idx;
            anc_we     = 1'b1;
            anc_waddr  = {v_idx, LW'(0)};
            anc_wdata  = p_idx;
            cur_d      = p_idx;
            state_d    = ST_EN_RDV;
          end
          FN_LEAVE: begin
            node_raddr = v_idx;
            state_d    = ST_LV_WR;
          end
          FN_QUERY: begin
            node_raddr = v_idx;
            cur_d      = v_idx;
            state_d    = ST_Q_RDB;
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_EN_RDV: begin
        node_raddr = v_idx;
        depth_d    = root_q ? '0 : node_rd.depth + DEPTH_W'(1);
        state_d    = ST_EN_WR;
      end

      // keep the node's old exit time, then start on jump level 1
      ST_EN_WR: begin
        node_we               = 1'b1;
        node_wdata.entry_time = ts_q + TIME_W'(1);
        node_wdata.exit_time  = node_rd.exit_time;
        node_wdata.depth      = depth_q;
        ts_d                  = ts_q + TIME_W'(1);
        anc_raddr             = {cur_q, LW'(0)};
        lvl_d                 = LW'(1);
        state_d               = ST_EN_LVL_WR;
      end

      ST_EN_LVL_RD: begin
        anc_raddr = {cur_q, lvl_q};
        lvl_d     = lvl_q + LW'(1);
        state_d   = ST_EN_LVL_WR;
      end

      // write lands before the next read, so a self-referencing row is safe
      ST_EN_LVL_WR: begin
        anc_we    = 1'b1;
        anc_waddr = {v_idx, lvl_q};
        anc_wdata = anc_rd;
        cur_d     = anc_rd;
        state_d   = (lvl_q == LvlTop) ? ST_IDLE : ST_EN_LVL_RD;
      end

      ST_LV_WR: begin
        node_we               = 1'b1;
        node_wdata.entry_time = node_rd.entry_time;
        node_wdata.exit_time  = ts_q + TIME_W'(1);
        node_wdata.depth      = node_rd.depth;
        ts_d                  = ts_q + TIME_W'(1);
        state_d               = ST_IDLE;
      end

      ST_Q_RDB: begin
        node_raddr = b_idx;
        a_rec_d    = node_rd;
        state_d    = ST_Q_TEST;
      end

      ST_Q_TEST: begin
        b_rec_d = node_rd;
        if (ab_anc) begin
          ca_d    = NODE_W'(v_idx);
          len_d   = path_len(a_rec_q.depth, node_rd.depth, a_rec_q.depth);
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (ba_anc) begin
          ca_d    = NODE_W'(b_idx);
          len_d   = path_len(a_rec_q.depth, node_rd.depth, node_rd.depth);
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          anc_raddr = {cur_q, LvlTop};
          lvl_d     = LvlTop;
          state_d   = ST_Q_UP;
        end
      end

      ST_Q_UP: begin
        up_d       = anc_rd;
        node_raddr = anc_rd;
        state_d    = ST_Q_CHK;
      end

      // climb only while the candidate does not contain the other node
      ST_Q_CHK: begin
        cur_d = a_next;
        if (lvl_q == LW'(0)) begin
          anc_raddr = {a_next, LW'(0)};
          state_d   = ST_Q_PAR;
        end else begin
          anc_raddr = {a_next, lvl_q - LW'(1)};
          lvl_d     = lvl_q - LW'(1);
          state_d   = ST_Q_UP;
        end
      end

      ST_Q_PAR: begin
        cur_d      = anc_rd;
        node_raddr = anc_rd;
        state_d    = ST_Q_LEN;
      end

      ST_Q_LEN: begin
        ca_d    = NODE_W'(cur_q);
        len_d   = path_len(a_rec_q.depth, b_rec_q.depth, node_rd.depth);
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign busy              = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign common_ancestor_o = ca_q;
  assign path_length_o     = len_q;

endmodule
